>>> hdl/srxl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srxl_pkg
// Types, constants and the CRC16 step shared by the frame receiver modules.
// ----------------------------------------------------------------------------
package srxl_pkg;

    localparam logic [7:0]  SYNC_12          = 8'hA1;
    localparam logic [7:0]  SYNC_16          = 8'hA2;
    localparam logic [15:0] CRC_POLY         = 16'h1021;
    localparam logic [16:0] IDLE_MAX         = 17'h1FFFF;
    localparam logic [4:0]  CHAN_12          = 5'd12;
    localparam logic [4:0]  CHAN_16          = 5'd16;
    localparam logic [15:0] GAP_LIMIT_RESET  = 16'd4000;
    localparam logic [11:0] CONV_MUL         = 12'd2735;
    localparam logic [15:0] CONV_OFFSET      = 16'd6400;
    // Reciprocal of 1000 scaled by 2^38, rounded up; exact for 28-bit dividends.
    localparam logic [28:0] RECIP_1000       = 29'd274877907;
    localparam int          RECIP_SHIFT      = 38;
    localparam logic        FUNC_BYTE        = 1'b0;
    localparam logic        FUNC_TICK        = 1'b1;
    localparam logic        REG_GAP_LIMIT    = 1'b0;

    typedef struct packed {
        logic       accept;
        logic       issue;
        logic       issue_err;
        logic       issue_last;
        logic [3:0] issue_idx;
    } t_ctrl_cmd;

    typedef struct packed {
        logic       frame_close;
        logic       crc_match;
        logic [4:0] used_count;
        logic       pipe_advance;
    } t_dp_status;

    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage
`default_nettype wire

>>> hdl/srxl_frame_receiver_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srxl_frame_receiver_unit
// Serial frame receiver with CRC16 check and per-channel value conversion.
// ----------------------------------------------------------------------------
// Bytes and ticks are accepted while the controller is idle. A closing byte holds off
// the input while its results are issued (up to MAX_CHANNELS, or one on a CRC error).
// After the closing byte the controller enters its emit state, then results pass
// one per cycle through the four-stage conversion pipeline while the output drains.
// Synchronous active-low reset clears the control state and sets the gap limit
// to 4000; stored channel words are not cleared.
// ----------------------------------------------------------------------------
module srxl_frame_receiver_unit #(
    parameter int MAX_CHANNELS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [3:0] channel_index, [19:4] raw_value, [35:20] converted_value,
    // [48:36] scaled_output, [49] crc_ok, [55:50] zero
    output logic [55:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [15:0]          r_gap_limit;
    srxl_pkg::t_ctrl_cmd  w_cmd;
    srxl_pkg::t_dp_status w_status;
    logic [3:0]           w_idx;
    logic [15:0]          w_raw;
    logic [15:0]          w_conv;
    logic [12:0]          w_scaled;
    logic                 w_crc_ok;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == srxl_pkg::REG_GAP_LIMIT) ? {16'd0, r_gap_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_limit <= srxl_pkg::GAP_LIMIT_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == srxl_pkg::REG_GAP_LIMIT)) begin
            r_gap_limit <= pwdata[15:0];
        end
    end

    srxl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    srxl_dp #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_func            (s_axis_tuser),
        .i_data_byte       (s_axis_tdata),
        .i_gap_limit       (r_gap_limit),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .o_valid           (m_axis_tvalid),
        .i_ready           (m_axis_tready),
        .o_channel_index   (w_idx),
        .o_raw_value       (w_raw),
        .o_converted_value (w_conv),
        .o_scaled_output   (w_scaled),
        .o_crc_ok          (w_crc_ok),
        .o_last            (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, w_crc_ok, w_scaled, w_conv, w_raw, w_idx};

endmodule
`default_nettype wire

>>> hdl/srxl_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srxl_ctrl
// Controller that gates input transfers and issues one result per channel,
// or a single error result, after a frame closes.
// ----------------------------------------------------------------------------
module srxl_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire srxl_pkg::t_dp_status i_status,
    output srxl_pkg::t_ctrl_cmd      o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    t_state     r_state;
    logic [3:0] r_idx;
    logic [3:0] r_last_idx;
    logic       r_err;
    logic       w_accept;
    logic       w_issue;
    logic       w_last;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_issue    = (r_state == ST_EMIT) && i_status.pipe_advance;
    assign w_last     = r_err || (r_idx == r_last_idx);

    always_comb begin
        o_cmd.accept     = w_accept;
        o_cmd.issue      = w_issue;
        o_cmd.issue_err  = r_err;
        o_cmd.issue_last = w_last;
        o_cmd.issue_idx  = r_err ? 4'd0 : r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_idx      <= '0;
            r_last_idx <= '0;
            r_err      <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept && i_status.frame_close) begin
                        r_state    <= ST_EMIT;
                        r_idx      <= '0;
                        r_err      <= !i_status.crc_match;
                        r_last_idx <= 4'(i_status.used_count - 5'd1);
                    end
                end
                ST_EMIT: begin
                    if (w_issue) begin
                        if (w_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx <= r_idx + 4'd1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

>>> hdl/srxl_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srxl_dp
// Datapath: frame position tracking, CRC16, channel word storage and the
// pipelined value conversion feeding the output register.
// ----------------------------------------------------------------------------
module srxl_dp #(
    parameter int MAX_CHANNELS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_func,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic [15:0]          i_gap_limit,
    input  wire srxl_pkg::t_ctrl_cmd  i_cmd,
    output srxl_pkg::t_dp_status      o_status,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [3:0]                o_channel_index,
    output logic [15:0]               o_raw_value,
    output logic [15:0]               o_converted_value,
    output logic [12:0]               o_scaled_output,
    output logic                      o_crc_ok,
    output logic                      o_last
);

    localparam logic [4:0] MAX_CH = 5'(MAX_CHANNELS);

    logic [5:0]  r_pos;
    logic [4:0]  r_cnt;
    logic [15:0] r_crc;
    logic [7:0]  r_crc_high;
    logic [16:0] r_idle;
    logic [15:0] r_words [MAX_CHANNELS];

    logic        w_byte;
    logic [5:0]  w_pos_eff;
    logic [4:0]  w_cnt_eff;
    logic        w_sync;
    logic [15:0] w_crc_base;
    logic [6:0]  w_pos_inc;
    logic [6:0]  w_two_cnt;
    logic [4:0]  w_k;
    logic        w_in_words;

    assign w_byte     = i_cmd.accept && (i_func == srxl_pkg::FUNC_BYTE);
    assign w_pos_eff  = ({1'b0, i_gap_limit} < r_idle) ? 6'd0 : r_pos;
    assign w_sync     = (i_data_byte == srxl_pkg::SYNC_12) ||
                        (i_data_byte == srxl_pkg::SYNC_16);
    assign w_cnt_eff  = (w_pos_eff != 6'd0) ? r_cnt :
                        (i_data_byte == srxl_pkg::SYNC_12) ? srxl_pkg::CHAN_12 :
                        srxl_pkg::CHAN_16;
    assign w_crc_base = (w_pos_eff == 6'd0) ? 16'd0 : r_crc;
    assign w_pos_inc  = {1'b0, w_pos_eff} + 7'd1;
    assign w_two_cnt  = {1'b0, w_cnt_eff, 1'b0};
    assign w_k        = 5'((w_pos_eff - 6'd1) >> 1);
    assign w_in_words = (w_pos_eff != 6'd0) && ({1'b0, w_pos_eff} <= w_two_cnt);

    always_comb begin
        o_status.frame_close = (i_func == srxl_pkg::FUNC_BYTE) &&
                               (w_pos_eff != 6'd0) &&
                               (w_pos_inc == w_two_cnt + 7'd3);
        o_status.crc_match   = (r_crc == {r_crc_high, i_data_byte});
        o_status.used_count  = (r_cnt < MAX_CH) ? r_cnt : MAX_CH;
        o_status.pipe_advance = !o_valid || i_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_cnt  <= '0;
            r_crc  <= '0;
            r_idle <= '0;
        end else if (i_cmd.accept) begin
            if (i_func == srxl_pkg::FUNC_TICK) begin
                if (r_idle < srxl_pkg::IDLE_MAX) begin
                    r_idle <= r_idle + 17'd1;
                end
            end else begin
                r_idle <= '0;
                if (w_pos_eff == 6'd0 && !w_sync) begin
                    r_pos <= '0;
                end else begin
                    if (w_pos_eff == 6'd0) begin
                        r_cnt <= w_cnt_eff;
                    end
                    if (w_pos_inc < w_two_cnt + 7'd2) begin
                        r_crc <= srxl_pkg::crc_update(w_crc_base, i_data_byte);
                        r_pos <= w_pos_inc[5:0];
                    end else if (w_pos_inc != w_two_cnt + 7'd3) begin
                        r_pos <= w_pos_inc[5:0];
                    end else begin
                        r_pos <= '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_byte && w_in_words && (w_k < MAX_CH)) begin
            if (w_pos_eff[0]) begin
                r_words[w_k[3:0]][15:8] <= i_data_byte;
            end else begin
                r_words[w_k[3:0]][7:0] <= i_data_byte;
            end
        end
        if (w_byte && !w_in_words && ({1'b0, w_pos_eff} == w_two_cnt + 7'd1)) begin
            r_crc_high <= i_data_byte;
        end
    end

    // Conversion pipeline: word read, times 2735, divide by 1000, offset.
    logic        r1_v, r2_v, r3_v;
    logic        r1_err, r2_err, r3_err;
    logic        r1_last, r2_last, r3_last;
    logic [3:0]  r1_idx, r2_idx, r3_idx;
    logic [15:0] r1_raw, r2_raw, r3_raw;
    logic [27:0] r2_prod;
    logic [17:0] r3_quot;
    logic [56:0] w_recip_prod;
    logic [18:0] w_conv_sum;
    logic [15:0] w_conv;
    logic        w_adv;

    assign w_adv        = o_status.pipe_advance;
    assign w_recip_prod = {29'd0, r2_prod} * {28'd0, srxl_pkg::RECIP_1000};
    assign w_conv_sum   = {1'b0, r3_quot} + {3'd0, srxl_pkg::CONV_OFFSET};
    assign w_conv       = (w_conv_sum > 19'h0FFFF) ? 16'hFFFF : w_conv_sum[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            o_valid <= 1'b0;
        end else if (w_adv) begin
            r1_v    <= i_cmd.issue;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            o_valid <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_err  <= i_cmd.issue_err;
            r1_last <= i_cmd.issue_last;
            r1_idx  <= i_cmd.issue_idx;
            r1_raw  <= i_cmd.issue_err ? 16'd0 : r_words[i_cmd.issue_idx];

            r2_err  <= r1_err;
            r2_last <= r1_last;
            r2_idx  <= r1_idx;
            r2_raw  <= r1_raw;
            r2_prod <= {12'd0, r1_raw} * {16'd0, srxl_pkg::CONV_MUL};

            r3_err  <= r2_err;
            r3_last <= r2_last;
            r3_idx  <= r2_idx;
            r3_raw  <= r2_raw;
            r3_quot <= w_recip_prod[srxl_pkg::RECIP_SHIFT +: 18];

            o_channel_index   <= r3_idx;
            o_raw_value       <= r3_raw;
            o_converted_value <= r3_err ? 16'd0 : w_conv;
            o_scaled_output   <= r3_err ? 13'd0 : w_conv[15:3];
            o_crc_ok          <= !r3_err;
            o_last            <= r3_last;
        end
    end

endmodule
`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the serial frame receiver. Frames of 12 and 16
// channels with good and corrupted checksums, a cut-off frame, stray bytes and
// idle ticks are streamed in under random back-pressure. A scoreboard tracks
// the frame state, predicts every channel result and checks the output stream.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [2:0] GAP_LIMIT_ADDR = {srxl_pkg::REG_GAP_LIMIT, 2'b00};

    typedef struct {
        bit [3:0]  chan;
        bit [15:0] raw;
        bit [15:0] conv;
        bit [12:0] scaled;
        bit        crc_ok;
        bit        last;
    } t_channel_result;

    class frame_scoreboard;
        bit [15:0]       gap_limit = srxl_pkg::GAP_LIMIT_RESET;
        int              frame_pos = 0;
        int              chan_count = 0;
        bit [15:0]       frame_crc = '0;
        bit [7:0]        crc_high = '0;
        bit [15:0]       words [16];
        bit [16:0]       idle_ticks = '0;
        t_channel_result expected_channels [$];
        int              errors = 0;
        int              inputs_seen = 0;
        int              results_checked = 0;
        int              frames_good = 0;
        int              frames_bad = 0;

        function bit [15:0] crc_next(bit [15:0] crc, bit [7:0] b);
            bit [15:0] c;
            c = crc;
            for (int i = 7; i >= 0; i--) begin
                if (c[15] ^ b[i]) begin
                    c = {c[14:0], 1'b0} ^ srxl_pkg::CRC_POLY;
                end else begin
                    c = {c[14:0], 1'b0};
                end
            end
            return c;
        endfunction

        function bit [15:0] convert_raw(bit [15:0] raw);
            int unsigned v;
            v = 32'(raw);
            v = v * 32'(srxl_pkg::CONV_MUL) / 1000 + 32'(srxl_pkg::CONV_OFFSET);
            return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
        endfunction

        // Returns the number of results the transfer causes.
        function int note_input(bit func, bit [7:0] b);
            int              pos_next;
            int              slot;
            int              used;
            int              k;
            t_channel_result r;
            inputs_seen++;
            if (func == srxl_pkg::FUNC_TICK) begin
                if (idle_ticks != srxl_pkg::IDLE_MAX) begin
                    idle_ticks++;
                end
                return 0;
            end
            if (idle_ticks > {1'b0, gap_limit}) begin
                frame_pos = 0;
            end
            idle_ticks = '0;
            if (frame_pos == 0) begin
                if (b == srxl_pkg::SYNC_12) begin
                    chan_count = int'(srxl_pkg::CHAN_12);
                end else if (b == srxl_pkg::SYNC_16) begin
                    chan_count = int'(srxl_pkg::CHAN_16);
                end else begin
                    return 0;
                end
                frame_crc = '0;
            end
            if (frame_pos >= 1 && frame_pos <= 2 * chan_count) begin
                slot = (frame_pos - 1) / 2;
                if (slot < 16) begin
                    if (frame_pos % 2 == 1) begin
                        words[slot][15:8] = b;
                    end else begin
                        words[slot][7:0] = b;
                    end
                end
            end else if (frame_pos == 2 * chan_count + 1) begin
                crc_high = b;
            end
            pos_next = frame_pos + 1;
            if (pos_next < 2 * chan_count + 2) begin
                frame_crc = crc_next(frame_crc, b);
                frame_pos = pos_next;
                return 0;
            end
            if (pos_next != 2 * chan_count + 3) begin
                frame_pos = pos_next;
                return 0;
            end
            frame_pos = 0;
            if (frame_crc != {crc_high, b}) begin
                r.chan = '0;
                r.raw = '0;
                r.conv = '0;
                r.scaled = '0;
                r.crc_ok = 1'b0;
                r.last = 1'b1;
                expected_channels.push_back(r);
                frames_bad++;
                return 1;
            end
            used = (chan_count < 16) ? chan_count : 16;
            for (k = 0; k < used; k++) begin
                r.chan = k[3:0];
                r.raw = words[k];
                r.conv = convert_raw(words[k]);
                r.scaled = r.conv[15:3];
                r.crc_ok = 1'b1;
                r.last = (k == used - 1);
                expected_channels.push_back(r);
            end
            frames_good++;
            return used;
        endfunction

        task report(string what);
            errors++;
            $display("ERROR: %s", what);
        endtask

        task check_channel(bit [55:0] d, bit l);
            t_channel_result e;
            if (expected_channels.size() == 0) begin
                report($sformatf("result with nothing expected: data %h last %b", d, l));
                return;
            end
            e = expected_channels.pop_front();
            results_checked++;
            if (d[3:0] != e.chan) begin
                report($sformatf("channel index %0d, expected %0d", d[3:0], e.chan));
            end
            if (d[19:4] != e.raw) begin
                report($sformatf("ch %0d raw %h, expected %h", e.chan, d[19:4], e.raw));
            end
            if (d[35:20] != e.conv) begin
                report($sformatf("ch %0d converted %0d, expected %0d",
                                 e.chan, d[35:20], e.conv));
            end
            if (d[48:36] != e.scaled) begin
                report($sformatf("ch %0d scaled %0d, expected %0d",
                                 e.chan, d[48:36], e.scaled));
            end
            if (d[49] != e.crc_ok) begin
                report($sformatf("ch %0d crc_ok %b, expected %b", e.chan, d[49], e.crc_ok));
            end
            if (d[55:50] != '0) begin
                report($sformatf("ch %0d padding bits %b not zero", e.chan, d[55:50]));
            end
            if (l != e.last) begin
                report($sformatf("ch %0d last %b, expected %b", e.chan, l, e.last));
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    frame_scoreboard sb;
    int tx_idle_pct = 29;
    int rx_idle_pct = 78;
    int rx_hold = 0;
    int cur_limit = int'(srxl_pkg::GAP_LIMIT_RESET);
    int results_due = 0;

    srxl_frame_receiver_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // The long hold-off is counted here so that the sender keeps offering meanwhile.
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            m_axis_tready = 1'b0;
            rx_hold--;
        end else begin
            m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_channel(m_axis_tdata, m_axis_tlast);
        end
    end

    initial begin
        #4_000_000;
        $display("Timeout: %0d results still expected", sb.expected_channels.size());
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_item(input logic func, input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = func;
        s_axis_tdata = b;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        results_due += sb.note_input(func, b);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) begin
            send_item(srxl_pkg::FUNC_TICK, 8'($urandom_range(255)));
        end
    endtask

    // Ticks between frame bytes stay within the gap limit.
    task automatic frame_gap_ticks();
        int top;
        top = (cur_limit > 3) ? 3 : cur_limit;
        if (cur_limit <= 8 && $urandom_range(19) == 0) begin
            send_ticks(cur_limit);
        end else if ($urandom_range(4) == 0) begin
            send_ticks(int'($urandom_range(top)));
        end
    endtask

    task automatic send_frame(input int nch, input bit [15:0] w [16],
                              input bit corrupt, input int cut);
        bit [7:0]  stream [$];
        bit [15:0] crc;
        int        n;
        int        k;
        stream.push_back((nch == srxl_pkg::CHAN_16) ? srxl_pkg::SYNC_16 :
                                                      srxl_pkg::SYNC_12);
        for (k = 0; k < nch; k++) begin
            stream.push_back(w[k][15:8]);
            stream.push_back(w[k][7:0]);
        end
        crc = '0;
        foreach (stream[i]) begin
            crc = sb.crc_next(crc, stream[i]);
        end
        if (corrupt) begin
            crc ^= 16'h0001 << $urandom_range(15);
        end
        stream.push_back(crc[15:8]);
        stream.push_back(crc[7:0]);
        n = (cut > 0) ? cut : stream.size();
        for (k = 0; k < n; k++) begin
            if (k > 0) begin
                frame_gap_ticks();
            end
            send_item(srxl_pkg::FUNC_BYTE, stream[k]);
        end
    endtask

    function automatic void fill_words(output bit [15:0] w [16]);
        for (int k = 0; k < 16; k++) begin
            case ($urandom_range(7))
                0: w[k] = 16'h0000;
                1: w[k] = 16'hFFFF;
                2: w[k] = 16'($urandom_range(21620, 21623));
                default: w[k] = 16'($urandom);
            endcase
        end
    endfunction

    task automatic wait_drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.expected_channels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = wr;
        paddr = addr;
        pwdata = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        rdata = prdata;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic check_gap_limit();
        logic [31:0] rd;
        apb_access(1'b0, GAP_LIMIT_ADDR, '0, rd);
        if (rd !== {16'h0000, sb.gap_limit}) begin
            sb.report($sformatf("gap limit reads %h, expected %h", rd, sb.gap_limit));
        end
    endtask

    task automatic set_gap_limit(input logic [15:0] v);
        logic [31:0] rd;
        wait_drain();
        apb_access(1'b1, GAP_LIMIT_ADDR, {16'h0000, v}, rd);
        sb.gap_limit = v;
        cur_limit = int'(v);
        check_gap_limit();
    endtask

    initial begin
        bit [15:0] w [16];

        sb = new();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        check_gap_limit();

        send_ticks(2);
        send_item(srxl_pkg::FUNC_BYTE, 8'h00);
        send_item(srxl_pkg::FUNC_BYTE, 8'hA3);
        w = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 16'd21621, 16'd21622,
              16'h00FF, 16'hFF00, 16'h5555, 16'hAAAA, 16'h1234,
              16'd21620, 16'd21623, 16'h0100, 16'hFFFE};
        send_frame(int'(srxl_pkg::CHAN_16), w, 1'b0, 0);
        rx_hold = 300;
        send_item(srxl_pkg::FUNC_BYTE, 8'h55);
        send_item(srxl_pkg::FUNC_BYTE, 8'h3C);

        set_gap_limit(16'd0);
        tx_idle_pct = 78;
        rx_idle_pct = 29;
        fill_words(w);
        send_frame(int'(srxl_pkg::CHAN_16), w, 1'b0, 6);
        send_ticks(1);
        fill_words(w);
        send_frame(int'(srxl_pkg::CHAN_12), w, 1'b1, 0);

        set_gap_limit(16'hFFFF);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        fill_words(w);
        send_frame(int'(srxl_pkg::CHAN_12), w, 1'b0, 0);

        wait_drain();
        repeat (20) @(posedge i_clk);
        $display("Run covered %0d input transfers, %0d of %0d results checked, %0d good",
                 sb.inputs_seen, sb.results_checked, results_due, sb.frames_good);
        $display("and %0d failed-checksum frames, a cut-off frame and gap limits 4000, 0, 65535.",
                 sb.frames_bad);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/srxl_pkg.sv
hdl/srxl_ctrl.sv
hdl/srxl_dp.sv
hdl/srxl_frame_receiver_unit.sv
test/tb.sv
